// ----- rtl/rpws_pkg.sv -----
// rpws_pkg: shared types, constants and state encoding of the risk parity weight solver
// no dependencies; used by every file in rtl/
`default_nettype none

package rpws_pkg;

    localparam int MAX_ASSETS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ASSET_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FLOOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DOWN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_UP      = 3'd5;

    localparam logic [4:0]  ASSET_COUNT_RST  = 5'd16;
    localparam logic [15:0] ITER_LIMIT_RST   = 16'd1000;
    localparam logic [31:0] TOLERANCE_RST    = 32'd10995;
    localparam logic [31:0] WEIGHT_FLOOR_RST = 32'd4294967;
    localparam logic [16:0] STEP_DOWN_RST    = 17'd64881;
    localparam logic [16:0] STEP_UP_RST      = 17'd66191;

    // word actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_SOLVE = 1'b1;

    // arithmetic constants
    localparam logic [63:0] CAP_WEIGHT = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] CAP_RISK   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] CAP_NONE   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VOL_MAX    = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [5:0]  FB_INT     = 6'd0;
    localparam logic [5:0]  FB_WEIGHT  = 6'd32;
    localparam logic [5:0]  FB_RISK    = 6'd40;
    localparam int          SQRT_STEPS = 52;
    localparam int          SQRT_XW    = 104;

    typedef struct packed {
        logic               action;
        logic [3:0]         row;
        logic [3:0]         column;
        logic signed [31:0] cov_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  asset_index;
        logic [31:0] weight;
        logic [47:0] volatility;
        logic [15:0] iterations_used;
        logic        tolerance_met;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] cap;
        logic [5:0]  frac_bits;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] root;
    } sqrt_rsp_t;

    typedef struct packed {
        logic [31:0] weight;
        logic [63:0] sigma;
        logic [63:0] scratch;
    } vec_entry_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_W0_START, ST_W0_WAIT, ST_W0_WR, ST_LOOP,
        ST_SIG_RD, ST_SIG_MUL, ST_SIG_ACC,
        ST_VAR_RD, ST_VAR_HI, ST_VAR_LO, ST_VAR_SUM,
        ST_SQ_START, ST_SQ_WAIT, ST_TGT_START, ST_TGT_WAIT,
        ST_RC_RD, ST_RC_START, ST_RC_WAIT,
        ST_STEP_RD, ST_STEP_MUL, ST_STEP_WR,
        ST_NORM_RD, ST_NORM_START, ST_NORM_WAIT,
        ST_OUT_RD, ST_OUT_LD
    } rpws_state_t;

endpackage

`default_nettype wire

// ----- rtl/rpws_div.sv -----
// rpws_div: restoring divider, floor(num * 2^frac_bits / den) saturated at cap, one bit a cycle
// depends on rpws_pkg
`default_nettype none

module rpws_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rpws_pkg::div_req_t req,
    output rpws_pkg::div_rsp_t      rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [63:0] den_reg;
    logic [63:0] cap_reg;
    logic [63:0] rem_reg;
    logic [63:0] q_reg;
    logic        ovf_reg;
    logic [63:0] quo_reg;

    logic [64:0] rem_s;
    logic        ge;
    logic [64:0] rem_n;
    logic [63:0] q_n;
    logic        ovf_n;

    assign rem_s = {rem_reg, num_reg[63]};
    assign ge    = rem_s >= {1'b0, den_reg};
    assign rem_n = ge ? rem_s - {1'b0, den_reg} : rem_s;
    assign q_n   = {q_reg[62:0], ge};
    assign ovf_n = ovf_reg | q_reg[63];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64 + 7'(req.frac_bits);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.num;
            den_reg <= req.den;
            cap_reg <= req.cap;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[62:0], 1'b0};
            rem_reg <= rem_n[63:0];
            q_reg   <= q_n;
            ovf_reg <= ovf_n;
            if (cnt_reg == 7'd1) begin
                quo_reg <= (ovf_n || q_n > cap_reg) ? cap_reg : q_n;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/rpws_sqrt.sv -----
// rpws_sqrt: digit-by-digit square root, floor(sqrt(v * 2^40)), zero for v <= 0, one digit a cycle
// depends on rpws_pkg
`default_nettype none

module rpws_sqrt (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire rpws_pkg::sqrt_req_t req,
    output rpws_pkg::sqrt_rsp_t      rsp
);

    localparam int XW = rpws_pkg::SQRT_XW;

    logic                 busy_reg;
    logic                 done_reg;
    logic [5:0]           cnt_reg;
    logic [XW-1:0]        x_reg;
    logic [63:0]          rem_reg;
    logic [63:0]          root_reg;

    logic [63:0] rem_s;
    logic [63:0] trial;
    logic        ge;

    assign rem_s = {rem_reg[61:0], x_reg[XW-1:XW-2]};
    assign trial = {root_reg[61:0], 2'b01};
    assign ge    = rem_s >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(rpws_pkg::SQRT_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg    <= (req.radicand > 64'sd0) ? {req.radicand, 40'b0} : '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= {x_reg[XW-3:0], 2'b00};
            rem_reg  <= ge ? rem_s - trial : rem_s;
            root_reg <= {root_reg[62:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

`default_nettype wire

// ----- rtl/risk_parity_weight_solver.sv -----
// risk_parity_weight_solver: equal-risk-contribution weight solver, top level and sequencer
// depends on rpws_pkg, rpws_div, rpws_sqrt
`default_nettype none

// channel   | ports                          | word                        | accepted when
// ----------+--------------------------------+-----------------------------+-------------------
// input     | s_valid, s_ready, s_data       | rpws_pkg::in_item_t         | s_valid && s_ready
// result    | m_valid, m_ready, m_data       | rpws_pkg::out_item_t        | m_valid && m_ready
// config    | cfg_wr_en, cfg_index, cfg_wdata| register write, no read     | cfg_wr_en
//
// covariance write words stream back to back
// a solve word's run time depends on the iterations run (L) and the asset count (n); it is
// set by the single covariance memory read port, one multiply-accumulate per pass through
// ST_SIG_RD, ST_SIG_MUL and ST_SIG_ACC, and the bit-serial divider used for each asset
// the last result word sits in the output register while the next input word is taken
// reset is synchronous on aresetn; the covariance memory needs no clearing pass

module risk_parity_weight_solver #(
    parameter int MAX_ASSETS = rpws_pkg::MAX_ASSETS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [rpws_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rpws_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input words
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire rpws_pkg::in_item_t                s_data,
    // result words
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output rpws_pkg::out_item_t                    m_data
);

    localparam int IDXW      = $clog2(MAX_ASSETS);
    localparam int NW        = $clog2(MAX_ASSETS + 1);
    localparam int CAW       = 2 * IDXW;
    localparam int COV_DEPTH = 1 << CAW;

    // configuration registers
    logic [4:0]  asset_count_reg;
    logic [15:0] iter_limit_reg;
    logic [31:0] tolerance_reg;
    logic [31:0] floor_reg;
    logic [16:0] step_down_reg;
    logic [16:0] step_up_reg;

    // sequencer state
    rpws_pkg::rpws_state_t state_reg, state_next;
    logic [IDXW-1:0]        i_reg, i_next;
    logic [IDXW-1:0]        j_reg, j_next;
    logic [NW-1:0]          n_reg, n_next;
    logic [15:0]            it_reg, it_next;
    logic                   met_reg, met_next;
    logic                   final_reg, final_next;
    logic                   m_valid_reg, m_valid_next;

    // datapath registers
    logic signed [63:0]     acc_reg, acc_next;
    logic signed [63:0]     var_reg, var_next;
    logic [63:0]            t_reg, t_next;
    logic signed [63:0]     target_reg, target_next;
    logic [63:0]            maxdev_reg, maxdev_next;
    logic [63:0]            sum_reg, sum_next;
    logic [MAX_ASSETS-1:0]  over_reg, over_next;
    logic [31:0]            w0_reg, w0_next;
    logic [63:0]            hi_reg, hi_next;
    logic                   neg_reg, neg_next;
    logic [47:0]            vol_reg, vol_next;
    rpws_pkg::out_item_t    out_reg, out_next;

    // covariance memory, one write and one read port
    logic signed [31:0]     cov_mem [COV_DEPTH];
    logic                   cov_we;
    logic [CAW-1:0]         cov_waddr;
    logic [CAW-1:0]         cov_raddr;
    logic signed [31:0]     cov_rdata_reg;

    // per-asset vector memory: weight, sigma, scratch (p_i, then stepped weight)
    rpws_pkg::vec_entry_t   vec_mem [MAX_ASSETS];
    logic [IDXW-1:0]        vec_raddr;
    rpws_pkg::vec_entry_t   vec_rdata_reg;
    logic                   w_we, sig_we, scr_we;
    logic [31:0]            w_wdata;
    logic [63:0]            sig_wdata;
    logic [63:0]            scr_wdata;

    // shared multiplier, registered product
    logic signed [32:0]     mul_a, mul_b;
    logic signed [65:0]     prod_reg;

    // iterative units
    rpws_pkg::div_req_t     div_req;
    rpws_pkg::div_rsp_t     div_rsp;
    rpws_pkg::sqrt_req_t    sqrt_req;
    rpws_pkg::sqrt_rsp_t    sqrt_rsp;

    // helpers
    logic                   in_acc;
    logic                   cov_in_range;
    logic [NW-1:0]          n_clamp;
    logic                   last_i, last_j;
    logic signed [63:0]     prod_lo;
    logic signed [63:0]     sig_term;
    logic signed [63:0]     acc_sum;
    logic [63:0]            sig_mag;
    logic [63:0]            ws_r;
    logic signed [63:0]     ws_p;
    logic [63:0]            scr_mag;
    logic signed [63:0]     rc;
    logic signed [63:0]     dev_d;
    logic [63:0]            dev;
    logic [63:0]            maxdev_upd;
    logic [63:0]            nw_raw;
    logic [63:0]            nw_clamped;
    logic [63:0]            vol_sat;

    rpws_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    rpws_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .rsp     (sqrt_rsp)
    );

    assign s_ready = (state_reg == rpws_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign in_acc  = s_valid && s_ready;

    // write words beyond the matrix are dropped
    assign cov_in_range = (32'(s_data.row) < MAX_ASSETS) && (32'(s_data.column) < MAX_ASSETS);
    assign cov_we       = in_acc && (s_data.action == rpws_pkg::ACT_WRITE) && cov_in_range;
    assign cov_waddr    = {IDXW'(s_data.row), IDXW'(s_data.column)};

    // asset count: zero runs as one, above the matrix as the full matrix
    always_comb begin
        if (asset_count_reg == 5'd0) begin
            n_clamp = NW'(1);
        end else if (32'(asset_count_reg) > MAX_ASSETS) begin
            n_clamp = NW'(MAX_ASSETS);
        end else begin
            n_clamp = NW'(asset_count_reg);
        end
    end

    assign last_i = (i_reg == IDXW'(n_reg - NW'(1)));
    assign last_j = (j_reg == IDXW'(n_reg - NW'(1)));

    // sigma term: floor(C * w / 2^16)
    assign prod_lo  = prod_reg[63:0];
    assign sig_term = prod_lo >>> 16;
    assign acc_sum  = acc_reg + sig_term;

    // w * sigma, split into a high and a low partial product
    assign sig_mag = vec_rdata_reg.sigma[63] ? 64'(0) - vec_rdata_reg.sigma : vec_rdata_reg.sigma;
    assign ws_r    = hi_reg + {32'b0, prod_reg[63:32]};
    assign ws_p    = neg_reg ? 64'sd0 - $signed(ws_r) : $signed(ws_r);

    // risk contribution against the equal share
    assign scr_mag    = vec_rdata_reg.scratch[63] ? 64'(0) - vec_rdata_reg.scratch
                                                  : vec_rdata_reg.scratch;
    assign rc         = neg_reg ? 64'sd0 - $signed(div_rsp.quo) : $signed(div_rsp.quo);
    assign dev_d      = rc - target_reg;
    assign dev        = dev_d[63] ? 64'(0) - dev_d : dev_d;
    assign maxdev_upd = (dev > maxdev_reg) ? dev : maxdev_reg;

    // stepped weight, held at the floor
    assign nw_raw     = {31'b0, prod_reg[48:16]};
    assign nw_clamped = (nw_raw < {32'b0, floor_reg}) ? {32'b0, floor_reg} : nw_raw;

    assign vol_sat = (sqrt_rsp.root > rpws_pkg::VOL_MAX) ? rpws_pkg::VOL_MAX : sqrt_rsp.root;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asset_count_reg <= rpws_pkg::ASSET_COUNT_RST;
            iter_limit_reg  <= rpws_pkg::ITER_LIMIT_RST;
            tolerance_reg   <= rpws_pkg::TOLERANCE_RST;
            floor_reg       <= rpws_pkg::WEIGHT_FLOOR_RST;
            step_down_reg   <= rpws_pkg::STEP_DOWN_RST;
            step_up_reg     <= rpws_pkg::STEP_UP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rpws_pkg::CFG_ASSET_COUNT:  asset_count_reg <= cfg_wdata[4:0];
                rpws_pkg::CFG_ITER_LIMIT:   iter_limit_reg  <= cfg_wdata[15:0];
                rpws_pkg::CFG_TOLERANCE:    tolerance_reg   <= cfg_wdata;
                rpws_pkg::CFG_WEIGHT_FLOOR: floor_reg       <= cfg_wdata;
                rpws_pkg::CFG_STEP_DOWN:    step_down_reg   <= cfg_wdata[16:0];
                rpws_pkg::CFG_STEP_UP:      step_up_reg     <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (cov_we) begin
            cov_mem[cov_waddr] <= s_data.cov_value;
        end
        cov_rdata_reg <= cov_mem[cov_raddr];
    end

    always_ff @(posedge aclk) begin
        if (w_we) begin
            vec_mem[i_reg].weight <= w_wdata;
        end
        if (sig_we) begin
            vec_mem[i_reg].sigma <= sig_wdata;
        end
        if (scr_we) begin
            vec_mem[i_reg].scratch <= scr_wdata;
        end
        vec_rdata_reg <= vec_mem[vec_raddr];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rpws_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            n_reg       <= NW'(1);
            it_reg      <= '0;
            met_reg     <= 1'b0;
            final_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            n_reg       <= n_next;
            it_reg      <= it_next;
            met_reg     <= met_next;
            final_reg   <= final_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        var_reg    <= var_next;
        t_reg      <= t_next;
        target_reg <= target_next;
        maxdev_reg <= maxdev_next;
        sum_reg    <= sum_next;
        over_reg   <= over_next;
        w0_reg     <= w0_next;
        hi_reg     <= hi_next;
        neg_reg    <= neg_next;
        vol_reg    <= vol_next;
        out_reg    <= out_next;
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        n_next       = n_reg;
        it_next      = it_reg;
        met_next     = met_reg;
        final_next   = final_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        acc_next     = acc_reg;
        var_next     = var_reg;
        t_next       = t_reg;
        target_next  = target_reg;
        maxdev_next  = maxdev_reg;
        sum_next     = sum_reg;
        over_next    = over_reg;
        w0_next      = w0_reg;
        hi_next      = hi_reg;
        neg_next     = neg_reg;
        vol_next     = vol_reg;
        out_next     = out_reg;

        cov_raddr = {i_reg, j_reg};
        vec_raddr = i_reg;
        w_we      = 1'b0;
        sig_we    = 1'b0;
        scr_we    = 1'b0;
        w_wdata   = '0;
        sig_wdata = acc_sum;
        scr_wdata = '0;
        mul_a     = '0;
        mul_b     = '0;

        div_req.start     = 1'b0;
        div_req.num       = '0;
        div_req.den       = 64'(n_reg);
        div_req.cap       = rpws_pkg::CAP_NONE;
        div_req.frac_bits = rpws_pkg::FB_INT;
        sqrt_req.start    = 1'b0;
        sqrt_req.radicand = var_reg;

        unique case (state_reg)
            rpws_pkg::ST_IDLE: begin
                if (in_acc && s_data.action == rpws_pkg::ACT_SOLVE) begin
                    n_next     = n_clamp;
                    state_next = rpws_pkg::ST_W0_START;
                end
            end

            // equal start weight
            rpws_pkg::ST_W0_START: begin
                div_req.start     = 1'b1;
                div_req.num       = 64'd1;
                div_req.cap       = rpws_pkg::CAP_WEIGHT;
                div_req.frac_bits = rpws_pkg::FB_WEIGHT;
                state_next        = rpws_pkg::ST_W0_WAIT;
            end
            rpws_pkg::ST_W0_WAIT: begin
                if (div_rsp.done) begin
                    w0_next    = div_rsp.quo[31:0];
                    i_next     = '0;
                    state_next = rpws_pkg::ST_W0_WR;
                end
            end
            rpws_pkg::ST_W0_WR: begin
                w_we    = 1'b1;
                w_wdata = w0_reg;
                if (last_i) begin
                    it_next    = '0;
                    met_next   = 1'b0;
                    state_next = rpws_pkg::ST_LOOP;
                end else begin
                    i_next = i_reg + IDXW'(1);
                end
            end

            // iteration head: at the limit only the closing volatility pass runs
            rpws_pkg::ST_LOOP: begin
                final_next = (it_reg >= iter_limit_reg);
                i_next     = '0;
                j_next     = '0;
                acc_next   = '0;
                state_next = rpws_pkg::ST_SIG_RD;
            end

            // sigma = C * w
            rpws_pkg::ST_SIG_RD: begin
                vec_raddr  = j_reg;
                state_next = rpws_pkg::ST_SIG_MUL;
            end
            rpws_pkg::ST_SIG_MUL: begin
                mul_a      = {cov_rdata_reg[31], cov_rdata_reg};
                mul_b      = {1'b0, vec_rdata_reg.weight};
                state_next = rpws_pkg::ST_SIG_ACC;
            end
            rpws_pkg::ST_SIG_ACC: begin
                if (last_j) begin
                    sig_we   = 1'b1;
                    acc_next = '0;
                    j_next   = '0;
                    if (last_i) begin
                        i_next     = '0;
                        var_next   = '0;
                        state_next = rpws_pkg::ST_VAR_RD;
                    end else begin
                        i_next     = i_reg + IDXW'(1);
                        state_next = rpws_pkg::ST_SIG_RD;
                    end
                end else begin
                    acc_next   = acc_sum;
                    j_next     = j_reg + IDXW'(1);
                    state_next = rpws_pkg::ST_SIG_RD;
                end
            end

            // p_i = w_i * sigma_i, variance = sum of p_i
            rpws_pkg::ST_VAR_RD: begin
                state_next = rpws_pkg::ST_VAR_HI;
            end
            rpws_pkg::ST_VAR_HI: begin
                neg_next   = vec_rdata_reg.sigma[63];
                mul_a      = {1'b0, vec_rdata_reg.weight};
                mul_b      = {1'b0, sig_mag[63:32]};
                state_next = rpws_pkg::ST_VAR_LO;
            end
            rpws_pkg::ST_VAR_LO: begin
                hi_next    = prod_reg[63:0];
                mul_a      = {1'b0, vec_rdata_reg.weight};
                mul_b      = {1'b0, sig_mag[31:0]};
                state_next = rpws_pkg::ST_VAR_SUM;
            end
            rpws_pkg::ST_VAR_SUM: begin
                scr_we    = 1'b1;
                scr_wdata = ws_p;
                var_next  = var_reg + ws_p;
                if (last_i) begin
                    state_next = rpws_pkg::ST_SQ_START;
                end else begin
                    i_next     = i_reg + IDXW'(1);
                    state_next = rpws_pkg::ST_VAR_RD;
                end
            end

            // total risk
            rpws_pkg::ST_SQ_START: begin
                sqrt_req.start = 1'b1;
                state_next     = rpws_pkg::ST_SQ_WAIT;
            end
            rpws_pkg::ST_SQ_WAIT: begin
                if (sqrt_rsp.done) begin
                    t_next = sqrt_rsp.root;
                    i_next = '0;
                    if (final_reg) begin
                        vol_next   = vol_sat[47:0];
                        state_next = rpws_pkg::ST_OUT_RD;
                    end else if (sqrt_rsp.root == 64'd0) begin
                        // no risk: every weight steps up
                        over_next  = '0;
                        sum_next   = '0;
                        state_next = rpws_pkg::ST_STEP_RD;
                    end else begin
                        state_next = rpws_pkg::ST_TGT_START;
                    end
                end
            end

            // equal share target = T / n
            rpws_pkg::ST_TGT_START: begin
                div_req.start = 1'b1;
                div_req.num   = t_reg;
                state_next    = rpws_pkg::ST_TGT_WAIT;
            end
            rpws_pkg::ST_TGT_WAIT: begin
                if (div_rsp.done) begin
                    target_next = $signed(div_rsp.quo);
                    maxdev_next = '0;
                    state_next  = rpws_pkg::ST_RC_RD;
                end
            end

            // rc_i = p_i * 2^40 / T, worst deviation from the target
            rpws_pkg::ST_RC_RD: begin
                state_next = rpws_pkg::ST_RC_START;
            end
            rpws_pkg::ST_RC_START: begin
                neg_next          = vec_rdata_reg.scratch[63];
                div_req.start     = 1'b1;
                div_req.num       = scr_mag;
                div_req.den       = t_reg;
                div_req.cap       = rpws_pkg::CAP_RISK;
                div_req.frac_bits = rpws_pkg::FB_RISK;
                state_next        = rpws_pkg::ST_RC_WAIT;
            end
            rpws_pkg::ST_RC_WAIT: begin
                if (div_rsp.done) begin
                    over_next[i_reg] = (rc > target_reg);
                    maxdev_next      = maxdev_upd;
                    if (last_i) begin
                        i_next = '0;
                        if (maxdev_upd < {32'b0, tolerance_reg}) begin
                            met_next   = 1'b1;
                            final_next = 1'b1;
                            j_next     = '0;
                            acc_next   = '0;
                            state_next = rpws_pkg::ST_SIG_RD;
                        end else begin
                            sum_next   = '0;
                            state_next = rpws_pkg::ST_STEP_RD;
                        end
                    end else begin
                        i_next     = i_reg + IDXW'(1);
                        state_next = rpws_pkg::ST_RC_RD;
                    end
                end
            end

            // step each weight down or up, hold at the floor
            rpws_pkg::ST_STEP_RD: begin
                state_next = rpws_pkg::ST_STEP_MUL;
            end
            rpws_pkg::ST_STEP_MUL: begin
                mul_a      = {1'b0, vec_rdata_reg.weight};
                mul_b      = {16'b0, (over_reg[i_reg] ? step_down_reg : step_up_reg)};
                state_next = rpws_pkg::ST_STEP_WR;
            end
            rpws_pkg::ST_STEP_WR: begin
                scr_we    = 1'b1;
                scr_wdata = nw_clamped;
                sum_next  = sum_reg + nw_clamped;
                if (last_i) begin
                    i_next     = '0;
                    state_next = rpws_pkg::ST_NORM_RD;
                end else begin
                    i_next     = i_reg + IDXW'(1);
                    state_next = rpws_pkg::ST_STEP_RD;
                end
            end

            // renormalise to sum one; a zero sum writes zero weights
            rpws_pkg::ST_NORM_RD: begin
                state_next = rpws_pkg::ST_NORM_START;
            end
            rpws_pkg::ST_NORM_START: begin
                if (sum_reg == 64'd0) begin
                    w_we = 1'b1;
                    if (last_i) begin
                        it_next    = it_reg + 16'd1;
                        state_next = rpws_pkg::ST_LOOP;
                    end else begin
                        i_next     = i_reg + IDXW'(1);
                        state_next = rpws_pkg::ST_NORM_RD;
                    end
                end else begin
                    div_req.start     = 1'b1;
                    div_req.num       = vec_rdata_reg.scratch;
                    div_req.den       = sum_reg;
                    div_req.cap       = rpws_pkg::CAP_WEIGHT;
                    div_req.frac_bits = rpws_pkg::FB_WEIGHT;
                    state_next        = rpws_pkg::ST_NORM_WAIT;
                end
            end
            rpws_pkg::ST_NORM_WAIT: begin
                if (div_rsp.done) begin
                    w_we    = 1'b1;
                    w_wdata = div_rsp.quo[31:0];
                    if (last_i) begin
                        it_next    = it_reg + 16'd1;
                        state_next = rpws_pkg::ST_LOOP;
                    end else begin
                        i_next     = i_reg + IDXW'(1);
                        state_next = rpws_pkg::ST_NORM_RD;
                    end
                end
            end

            // result words, one per asset
            rpws_pkg::ST_OUT_RD: begin
                state_next = rpws_pkg::ST_OUT_LD;
            end
            rpws_pkg::ST_OUT_LD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    out_next.asset_index     = 4'(i_reg);
                    out_next.weight          = vec_rdata_reg.weight;
                    out_next.volatility      = vol_reg;
                    out_next.iterations_used = it_reg;
                    out_next.tolerance_met   = met_reg;
                    out_next.last            = last_i;
                    if (last_i) begin
                        state_next = rpws_pkg::ST_IDLE;
                    end else begin
                        i_next     = i_reg + IDXW'(1);
                        state_next = rpws_pkg::ST_OUT_RD;
                    end
                end
            end

            default: begin
                state_next = rpws_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/rpws_checker.sv -----
// rpws_checker: port-level assertions for the risk parity weight solver, bound to the top level
// depends on rpws_pkg and risk_parity_weight_solver
`default_nettype none

module rpws_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire rpws_pkg::in_item_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire rpws_pkg::out_item_t m_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // out of reset the block is empty and takes input
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

    // a solve word closes the input until its last result word is loaded
    a_solve_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == rpws_pkg::ACT_SOLVE |=> !s_ready)
        else $error("input open right after a solve word");

    // a covariance write leaves the input open
    a_write_open: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == rpws_pkg::ACT_WRITE |=> s_ready)
        else $error("input closed after a write word");

    // while a run still has words to deliver no input is taken
    a_run_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> !s_ready)
        else $error("input open in the middle of a run's results");

endmodule

bind risk_parity_weight_solver rpws_checker u_rpws_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
